// File: src/depth_min_pool_downscale_defines.svh
`ifndef DEPTH_MIN_POOL_DOWNSCALE_DEFINES_SVH
`define DEPTH_MIN_POOL_DOWNSCALE_DEFINES_SVH

// Same-cycle check: the consequent must hold whenever the antecedent holds.
`define DMPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmpd check failed: same-cycle rule");

// Next-cycle check: the consequent must hold in the cycle after the antecedent.
`define DMPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmpd check failed: next-cycle rule");

`endif

// File: src/dmpd_pkg.sv
package dmpd_pkg;

  // Store and field sizes.
  localparam int MAX_CELLS  = 4096;
  localparam int CELL_AW    = $clog2(MAX_CELLS);
  localparam int DEPTH_BITS = 16;
  localparam int PIX_W      = 12;
  localparam int CFG_IN_W   = 13;
  localparam int CFG_OUT_W  = 7;
  localparam int GRID_W     = 6;
  localparam int GRID_MAX   = 64;
  localparam int PROD_W     = PIX_W + GRID_W;
  localparam int DIV_STEPS  = GRID_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  localparam logic [DEPTH_BITS-1:0] DEPTH_INF = {DEPTH_BITS{1'b1}};

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_IN_WIDTH   = 2'd0,
    REG_IN_HEIGHT  = 2'd1,
    REG_OUT_WIDTH  = 2'd2,
    REG_OUT_HEIGHT = 2'd3
  } dmpd_reg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_IDX,
    ST_RD,
    ST_UPD
  } dmpd_state_t;

  // Configuration register contents.
  typedef struct packed {
    logic [CFG_IN_W-1:0]  in_width;
    logic [CFG_IN_W-1:0]  in_height;
    logic [CFG_OUT_W-1:0] out_width;
    logic [CFG_OUT_W-1:0] out_height;
  } dmpd_cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;
    logic load;
    logic mul;
    logic div_step;
    logic idx;
    logic rd;
    logic upd;
  } dmpd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;
    logic bad;
    logic out_busy;
  } dmpd_sts_t;

  // Grid size as used: zero acts as one, anything above the maximum as the maximum.
  function automatic logic [CFG_OUT_W-1:0] clamp_grid(input logic [CFG_OUT_W-1:0] v);
    logic [CFG_OUT_W-1:0] r;
    if (v == '0) begin
      r = CFG_OUT_W'(1);
    end else if (v > CFG_OUT_W'(GRID_MAX)) begin
      r = CFG_OUT_W'(GRID_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: src/dmpd_cfg.sv
module dmpd_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [dmpd_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [dmpd_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [dmpd_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready,
  output dmpd_pkg::dmpd_cfg_t                cfg
);

  dmpd_pkg::dmpd_cfg_t cfg_r;
  dmpd_pkg::dmpd_reg_t reg_sel;
  logic                wr_en;

  assign cfg_pready = 1'b1;
  assign reg_sel    = dmpd_pkg::dmpd_reg_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  // Register file with reset values of a VGA frame and a 64x48 grid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_width   <= dmpd_pkg::CFG_IN_W'(640);
      cfg_r.in_height  <= dmpd_pkg::CFG_IN_W'(480);
      cfg_r.out_width  <= dmpd_pkg::CFG_OUT_W'(64);
      cfg_r.out_height <= dmpd_pkg::CFG_OUT_W'(48);
    end else if (wr_en) begin
      case (reg_sel)
        dmpd_pkg::REG_IN_WIDTH:   cfg_r.in_width   <= cfg_pwdata[dmpd_pkg::CFG_IN_W-1:0];
        dmpd_pkg::REG_IN_HEIGHT:  cfg_r.in_height  <= cfg_pwdata[dmpd_pkg::CFG_IN_W-1:0];
        dmpd_pkg::REG_OUT_WIDTH:  cfg_r.out_width  <= cfg_pwdata[dmpd_pkg::CFG_OUT_W-1:0];
        dmpd_pkg::REG_OUT_HEIGHT: cfg_r.out_height <= cfg_pwdata[dmpd_pkg::CFG_OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_sel)
      dmpd_pkg::REG_IN_WIDTH:   cfg_prdata = dmpd_pkg::CFG_DW'(cfg_r.in_width);
      dmpd_pkg::REG_IN_HEIGHT:  cfg_prdata = dmpd_pkg::CFG_DW'(cfg_r.in_height);
      dmpd_pkg::REG_OUT_WIDTH:  cfg_prdata = dmpd_pkg::CFG_DW'(cfg_r.out_width);
      dmpd_pkg::REG_OUT_HEIGHT: cfg_prdata = dmpd_pkg::CFG_DW'(cfg_r.out_height);
      default:                  cfg_prdata = '0;
    endcase
  end

endmodule

// File: src/dmpd_ctrl.sv
module dmpd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  dmpd_pkg::dmpd_sts_t sts,
  output dmpd_pkg::dmpd_cmd_t cmd
);

  dmpd_pkg::dmpd_state_t            state_r, state_nxt;
  logic [dmpd_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmpd_pkg::ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      dmpd_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = dmpd_pkg::ST_IDLE;
        end
      end
      dmpd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = dmpd_pkg::ST_MUL;
        end
      end
      dmpd_pkg::ST_MUL: begin
        // Bad pixels skip the division and the cell store.
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.bad ? dmpd_pkg::ST_UPD : dmpd_pkg::ST_DIV;
      end
      dmpd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == dmpd_pkg::DIV_CNT_W'(dmpd_pkg::DIV_STEPS - 1)) begin
          state_nxt = dmpd_pkg::ST_IDX;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      dmpd_pkg::ST_IDX: begin
        cmd.idx   = 1'b1;
        state_nxt = dmpd_pkg::ST_RD;
      end
      dmpd_pkg::ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = dmpd_pkg::ST_UPD;
      end
      dmpd_pkg::ST_UPD: begin
        // Wait until the output register can take the result.
        if (!sts.out_busy) begin
          cmd.upd   = 1'b1;
          state_nxt = dmpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dmpd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/dmpd_dp.sv
module dmpd_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dmpd_pkg::dmpd_cfg_t               cfg,
  input  dmpd_pkg::dmpd_cmd_t               cmd,
  output dmpd_pkg::dmpd_sts_t               sts,
  input  logic [dmpd_pkg::PIX_W-1:0]        pixel_x,
  input  logic [dmpd_pkg::PIX_W-1:0]        pixel_y,
  input  logic [dmpd_pkg::DEPTH_BITS-1:0]   depth,
  input  logic                              frame_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dmpd_pkg::GRID_W-1:0]       cell_x,
  output logic [dmpd_pkg::GRID_W-1:0]       cell_y,
  output logic [dmpd_pkg::DEPTH_BITS-1:0]   cell_depth,
  output logic                              bad_pixel
);

  localparam int WORD_W = dmpd_pkg::DEPTH_BITS + 1;
  localparam int MUL_W  = dmpd_pkg::PIX_W + dmpd_pkg::CFG_OUT_W;
  localparam int IDX_W  = dmpd_pkg::GRID_W + dmpd_pkg::CFG_OUT_W;

  // Cell store: tag bit above the running minimum.
  logic [WORD_W-1:0] mem [dmpd_pkg::MAX_CELLS];

  logic [dmpd_pkg::PIX_W-1:0]      px_r, py_r;
  logic [dmpd_pkg::DEPTH_BITS-1:0] d_r;
  logic                            tag_r;
  logic [dmpd_pkg::PROD_W-1:0]     rem_x_r, rem_y_r, dvs_x_r, dvs_y_r;
  logic [dmpd_pkg::GRID_W-1:0]     q_x_r, q_y_r;
  logic [dmpd_pkg::CELL_AW-1:0]    idx_r, clr_cnt_r;
  logic [WORD_W-1:0]               rd_word_r;
  logic                            out_valid_r;
  logic [dmpd_pkg::GRID_W-1:0]     cell_x_r, cell_y_r;
  logic [dmpd_pkg::DEPTH_BITS-1:0] cell_depth_r;
  logic                            bad_pixel_r;

  logic [dmpd_pkg::CFG_OUT_W-1:0]  ow, oh;
  logic                            bad;
  logic [MUL_W-1:0]                prod_x, prod_y;
  logic                            ge_x, ge_y;
  logic [IDX_W-1:0]                idx_sum;
  logic [dmpd_pkg::DEPTH_BITS-1:0] cur_min, new_min;

  assign ow  = dmpd_pkg::clamp_grid(cfg.out_width);
  assign oh  = dmpd_pkg::clamp_grid(cfg.out_height);
  assign bad = ({1'b0, px_r} >= cfg.in_width) || ({1'b0, py_r} >= cfg.in_height);

  assign prod_x  = MUL_W'(px_r) * MUL_W'(ow);
  assign prod_y  = MUL_W'(py_r) * MUL_W'(oh);
  assign ge_x    = rem_x_r >= dvs_x_r;
  assign ge_y    = rem_y_r >= dvs_y_r;
  assign idx_sum = IDX_W'(q_y_r) * IDX_W'(ow) + IDX_W'(q_x_r);

  // A cell from an older frame reads as infinity.
  assign cur_min = (rd_word_r[WORD_W-1] == tag_r) ? rd_word_r[dmpd_pkg::DEPTH_BITS-1:0]
                                                   : dmpd_pkg::DEPTH_INF;
  assign new_min = (d_r < cur_min) ? d_r : cur_min;

  assign sts.clear_last = clr_cnt_r == dmpd_pkg::CELL_AW'(dmpd_pkg::MAX_CELLS - 1);
  assign sts.bad        = bad;
  assign sts.out_busy   = out_valid_r & ~out_ready;

  // Request capture and frame tag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= 1'b0;
    end else if (cmd.load && frame_start) begin
      tag_r <= ~tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= pixel_x;
      py_r <= pixel_y;
      d_r  <= depth;
    end
  end

  // Scaling product, then restoring division one quotient bit per step.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem_x_r <= prod_x[dmpd_pkg::PROD_W-1:0];
      rem_y_r <= prod_y[dmpd_pkg::PROD_W-1:0];
      dvs_x_r <= {cfg.in_width, {dmpd_pkg::GRID_W-1{1'b0}}};
      dvs_y_r <= {cfg.in_height, {dmpd_pkg::GRID_W-1{1'b0}}};
      q_x_r   <= '0;
      q_y_r   <= '0;
    end else if (cmd.div_step) begin
      if (ge_x) begin
        rem_x_r <= rem_x_r - dvs_x_r;
      end
      if (ge_y) begin
        rem_y_r <= rem_y_r - dvs_y_r;
      end
      dvs_x_r <= dvs_x_r >> 1;
      dvs_y_r <= dvs_y_r >> 1;
      q_x_r   <= {q_x_r[dmpd_pkg::GRID_W-2:0], ge_x};
      q_y_r   <= {q_y_r[dmpd_pkg::GRID_W-2:0], ge_y};
    end
  end

  // Cell address, wrapped to the store size.
  always_ff @(posedge clk) begin
    if (cmd.idx) begin
      idx_r <= idx_sum[dmpd_pkg::CELL_AW-1:0];
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Store write port: clearing pass, then read-modify-write of one cell.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.upd && !bad) begin
      mem[idx_r] <= {tag_r, new_min};
    end
  end

  // Store read port.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_word_r <= mem[idx_r];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.upd) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      if (bad) begin
        cell_x_r     <= '0;
        cell_y_r     <= '0;
        cell_depth_r <= dmpd_pkg::DEPTH_INF;
        bad_pixel_r  <= 1'b1;
      end else begin
        cell_x_r     <= q_x_r;
        cell_y_r     <= q_y_r;
        cell_depth_r <= new_min;
        bad_pixel_r  <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign cell_x     = cell_x_r;
  assign cell_y     = cell_y_r;
  assign cell_depth = cell_depth_r;
  assign bad_pixel  = bad_pixel_r;

endmodule

// File: src/depth_min_pool_downscale.sv
// A pixel is accepted in idle, then passes the multiply, 6-step divide, index, read and update
// states (a bad pixel goes from multiply to update); update waits while the output is held. A
// new pixel is taken only after the last has left update, as the x and y dividers and the cell
// store read-modify-write serve one pixel at a time. Reset (rst_n, synchronous, active low)
// restores the registers and clears all 4096 cells, taking no pixel then; writes still land.
`include "depth_min_pool_downscale_defines.svh"

module depth_min_pool_downscale (
  input  logic                           clk,
  input  logic                           rst_n,
  // pixel_x [11:0], pixel_y [23:12], depth [39:24]
  input  logic [39:0]                    in_tdata,
  // frame_start [0]
  input  logic                           in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // cell_x [5:0], cell_y [11:6], cell_depth [27:12], zero fill [31:28]
  output logic [31:0]                    out_tdata,
  // bad_pixel [0]
  output logic                           out_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [dmpd_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [dmpd_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [dmpd_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);

  dmpd_pkg::dmpd_cfg_t             cfg;
  dmpd_pkg::dmpd_cmd_t             cmd;
  dmpd_pkg::dmpd_sts_t             sts;
  logic [dmpd_pkg::GRID_W-1:0]     cell_x, cell_y;
  logic [dmpd_pkg::DEPTH_BITS-1:0] cell_depth;
  logic [dmpd_pkg::CFG_OUT_W-1:0]  ow_eff;
  logic                            cell_x_ok;

  dmpd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  dmpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dmpd_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .pixel_x     (in_tdata[11:0]),
    .pixel_y     (in_tdata[23:12]),
    .depth       (in_tdata[39:24]),
    .frame_start (in_tuser),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .cell_depth  (cell_depth),
    .bad_pixel   (out_tuser)
  );

  assign out_tdata = {4'b0, cell_depth, cell_y, cell_x};

  // A good result always names a column inside the grid as used.
  assign ow_eff    = dmpd_pkg::clamp_grid(cfg.out_width);
  assign cell_x_ok = {1'b0, cell_x} < ow_eff;

  `DMPD_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)
  `DMPD_ASSERT_NOW(a_bad_is_inf, out_tvalid && out_tuser, out_tdata[27:12] == 16'hFFFF)
  `DMPD_ASSERT_NOW(a_cell_in_grid, out_tvalid && !out_tuser, cell_x_ok)

endmodule
